### rtl/core/pdmp_pkg.sv
// ----------------------------------------------------------------------------
// pdmp_pkg: shared definitions for the palette to mono dither packer
// Widths, palette geometry, luminance weights and the structs that pass
// between the palette stage and the packing stage.
// ----------------------------------------------------------------------------
package pdmp_pkg;

  // Payload widths of the input and result items.
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned COMP_W  = 6;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CODE_W  = 2;

  // Palette geometry.
  localparam int unsigned PAL_ENTRIES = 256;
  localparam int unsigned PAL_AW      = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
  localparam int unsigned PAL_W       = 3 * COMP_W;

  // Division by 100 is done as a multiply by ceil(2^19/100) and a shift.
  // The error stays below one part in a thousand for products up to 63*59,
  // so each truncated term comes out exact. The weight is folded in.
  localparam int unsigned DIV_SHIFT   = 19;
  localparam int unsigned DIV_RECIP   = ((1 << DIV_SHIFT) + 99) / 100;
  localparam int unsigned RED_MUL     = 30 * DIV_RECIP;
  localparam int unsigned GREEN_MUL   = 59 * DIV_RECIP;
  localparam int unsigned BLUE_MUL    = 11 * DIV_RECIP;
  localparam int unsigned PROD_W      = 26;
  localparam int unsigned LUMA_W      = 7;

  // Luminance offset and dither thresholds.
  localparam int unsigned BLACK_LIFT  = 12;
  localparam int unsigned THR_DARK    = 12;
  localparam int unsigned THR_LOW     = 25;
  localparam int unsigned THR_MID     = 36;
  localparam int unsigned THR_HIGH    = 49;

  // Item kinds.
  typedef enum logic {
    ACT_PIXEL  = 1'b0,
    ACT_PAL_WR = 1'b1
  } action_e;

  // One accepted input item, as seen by the palette stage.
  typedef struct packed {
    logic                accept;
    action_e             action;
    logic [INDEX_W-1:0]  index;
    logic [COMP_W-1:0]   red;
    logic [COMP_W-1:0]   green;
    logic [COMP_W-1:0]   blue;
    logic                line_odd;
    logic                row_end;
  } req_t;

  // A pixel after its palette lookup.
  typedef struct packed {
    logic                valid;
    logic                nonzero;
    logic                line_odd;
    logic                row_end;
    logic [COMP_W-1:0]   red;
    logic [COMP_W-1:0]   green;
    logic [COMP_W-1:0]   blue;
  } pix_t;

endpackage

### rtl/core/pdmp_in_if.sv
// ----------------------------------------------------------------------------
// pdmp_in_if: input channel of the palette to mono dither packer
// Carries palette writes and pixels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pdmp_in_if;
  logic                              valid;
  logic                              ready;
  logic                              action;
  logic [pdmp_pkg::INDEX_W-1:0]      index;
  logic [pdmp_pkg::COMP_W-1:0]       red;
  logic [pdmp_pkg::COMP_W-1:0]       green;
  logic [pdmp_pkg::COMP_W-1:0]       blue;
  logic                              line_odd;
  logic                              row_end;

  modport source (
    output valid, action, index, red, green, blue, line_odd, row_end,
    input  ready
  );
  modport sink (
    input  valid, action, index, red, green, blue, line_odd, row_end,
    output ready
  );
endinterface

### rtl/core/pdmp_out_if.sv
// ----------------------------------------------------------------------------
// pdmp_out_if: output channel of the palette to mono dither packer
// Carries packed bytes of up to four 2-bit codes with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pdmp_out_if;
  logic                          valid;
  logic                          ready;
  logic [pdmp_pkg::BYTE_W-1:0]   packed_byte;

  modport source (
    output valid, packed_byte,
    input  ready
  );
  modport sink (
    input  valid, packed_byte,
    output ready
  );
endinterface

### rtl/core/pdmp_ram.sv
// ----------------------------------------------------------------------------
// pdmp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when no
// read is requested.
// ----------------------------------------------------------------------------
module pdmp_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage array and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/pdmp_palette.sv
// ----------------------------------------------------------------------------
// pdmp_palette: palette store and lookup stage
// Writes palette entries, reads the entry of each pixel and holds the
// pixel's side information until the packing stage takes it.
// ----------------------------------------------------------------------------
module pdmp_palette (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pdmp_pkg::req_t      req_i,
  input  logic                hold_i,
  output pdmp_pkg::pix_t      pix_o
);

  logic [pdmp_pkg::PAL_AW-1:0]      addr;
  logic                             in_range;
  logic                             wr_en;
  logic                             rd_en;
  logic [pdmp_pkg::PAL_ENTRIES-1:0] written_q;
  logic [pdmp_pkg::PAL_W-1:0]       rdata;
  logic                             valid_q;
  logic                             hit_q;
  logic                             nonzero_q;
  logic                             odd_q;
  logic                             end_q;

  // Address decode; indexes past the palette write nothing and read zero.
  assign addr     = req_i.index[pdmp_pkg::PAL_AW-1:0];
  assign in_range = ({1'b0, req_i.index} < (pdmp_pkg::INDEX_W + 1)'(pdmp_pkg::PAL_ENTRIES));
  assign wr_en    = req_i.accept && (req_i.action == pdmp_pkg::ACT_PAL_WR) && in_range;
  assign rd_en    = req_i.accept && (req_i.action == pdmp_pkg::ACT_PIXEL);

  pdmp_ram #(
    .WIDTH (pdmp_pkg::PAL_W),
    .DEPTH (pdmp_pkg::PAL_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (addr),
    .wdata_i ({req_i.red, req_i.green, req_i.blue}),
    .re_i    (rd_en),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  // Entries that were never written since reset read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (wr_en) begin
      written_q[addr] <= 1'b1;
    end
  end

  // Lookup stage register; it holds while the packing stage is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!hold_i) begin
      valid_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      hit_q     <= in_range && written_q[addr];
      nonzero_q <= (req_i.index != '0);
      odd_q     <= req_i.line_odd;
      end_q     <= req_i.row_end;
    end
  end

  // Pixel as seen by the packing stage.
  always_comb begin
    pix_o.valid    = valid_q;
    pix_o.nonzero  = nonzero_q;
    pix_o.line_odd = odd_q;
    pix_o.row_end  = end_q;
    pix_o.red      = hit_q ? rdata[3*pdmp_pkg::COMP_W-1:2*pdmp_pkg::COMP_W] : '0;
    pix_o.green    = hit_q ? rdata[2*pdmp_pkg::COMP_W-1:pdmp_pkg::COMP_W]   : '0;
    pix_o.blue     = hit_q ? rdata[pdmp_pkg::COMP_W-1:0]                     : '0;
  end

endmodule

### rtl/core/pdmp_pack.sv
// ----------------------------------------------------------------------------
// pdmp_pack: luminance, dither and byte packing stage
// Turns a looked-up pixel into a 2-bit code, packs up to four codes per byte and
// holds the finished byte in the output register.
// ----------------------------------------------------------------------------
module pdmp_pack (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pdmp_pkg::pix_t                pix_i,
  input  logic                          lift_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [pdmp_pkg::BYTE_W-1:0]   packed_byte_o,
  output logic                          hold_o
);

  localparam logic [pdmp_pkg::CODE_W-1:0] CODE_BLACK = 2'd0;
  localparam logic [pdmp_pkg::CODE_W-1:0] CODE_DARK  = 2'd1;
  localparam logic [pdmp_pkg::CODE_W-1:0] CODE_LIGHT = 2'd2;
  localparam logic [pdmp_pkg::CODE_W-1:0] CODE_WHITE = 2'd3;
  localparam logic [1:0]                  LAST_SLOT  = 2'd3;

  logic [pdmp_pkg::PROD_W-1:0]  r_prod;
  logic [pdmp_pkg::PROD_W-1:0]  g_prod;
  logic [pdmp_pkg::PROD_W-1:0]  b_prod;
  logic [pdmp_pkg::LUMA_W-1:0]  luma;
  logic [pdmp_pkg::LUMA_W-1:0]  luma_adj;
  logic [pdmp_pkg::CODE_W-1:0]  code;
  logic [pdmp_pkg::BYTE_W-1:0]  acc_q, acc_d;
  logic [pdmp_pkg::BYTE_W-1:0]  merged;
  logic [1:0]                   slot_q, slot_d;
  logic                         emit;
  logic                         fire;
  logic                         out_valid_q, out_valid_d;
  logic [pdmp_pkg::BYTE_W-1:0]  byte_q, byte_d;

  // Weighted terms, each divided by 100 through the reciprocal.
  assign r_prod = pdmp_pkg::PROD_W'(pix_i.red)   * pdmp_pkg::PROD_W'(pdmp_pkg::RED_MUL);
  assign g_prod = pdmp_pkg::PROD_W'(pix_i.green) * pdmp_pkg::PROD_W'(pdmp_pkg::GREEN_MUL);
  assign b_prod = pdmp_pkg::PROD_W'(pix_i.blue)  * pdmp_pkg::PROD_W'(pdmp_pkg::BLUE_MUL);

  assign luma = pdmp_pkg::LUMA_W'(r_prod >> pdmp_pkg::DIV_SHIFT)
              + pdmp_pkg::LUMA_W'(g_prod >> pdmp_pkg::DIV_SHIFT)
              + pdmp_pkg::LUMA_W'(b_prod >> pdmp_pkg::DIV_SHIFT);

  assign luma_adj = (lift_i && pix_i.nonzero)
                  ? luma + pdmp_pkg::LUMA_W'(pdmp_pkg::BLACK_LIFT) : luma;

  // Thresholds with the two-row ordered dither.
  always_comb begin
    priority if (luma_adj < pdmp_pkg::LUMA_W'(pdmp_pkg::THR_DARK)) begin
      code = CODE_BLACK;
    end else if (luma_adj < pdmp_pkg::LUMA_W'(pdmp_pkg::THR_LOW)) begin
      code = pix_i.line_odd ? CODE_BLACK : CODE_DARK;
    end else if (luma_adj < pdmp_pkg::LUMA_W'(pdmp_pkg::THR_MID)) begin
      code = CODE_LIGHT;
    end else if (luma_adj < pdmp_pkg::LUMA_W'(pdmp_pkg::THR_HIGH)) begin
      code = pix_i.line_odd ? CODE_LIGHT : CODE_WHITE;
    end else begin
      code = CODE_WHITE;
    end
  end

  // The stage stalls only when it must emit and the output is still full.
  assign emit   = (slot_q == LAST_SLOT) || pix_i.row_end;
  assign hold_o = pix_i.valid && emit && out_valid_q && !out_ready_i;
  assign fire   = pix_i.valid && !hold_o;

  // Slot 0 lands in bits 7:6, so the shift is twice the inverted slot.
  assign merged = acc_q | (pdmp_pkg::BYTE_W'(code) << {~slot_q, 1'b0});

  always_comb begin
    acc_d       = acc_q;
    slot_d      = slot_q;
    byte_d      = byte_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (fire) begin
      if (emit) begin
        acc_d       = '0;
        slot_d      = '0;
        byte_d      = merged;
        out_valid_d = 1'b1;
      end else begin
        acc_d  = merged;
        slot_d = slot_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign out_valid_o   = out_valid_q;
  assign packed_byte_o = byte_q;

endmodule

### rtl/core/palette_to_mono_dither_packer.sv
// ----------------------------------------------------------------------------
// palette_to_mono_dither_packer: palette pixels to packed 2-bit mono bytes
// Looks up 8-bit colour indexes in a 256-entry palette, forms a dithered
// 2-bit code per pixel and packs up to four codes per byte, a row end closing a byte early.
// ----------------------------------------------------------------------------
//   Channel    Dir  Handshake        Content
//   in_i       in   valid/ready      palette write or pixel
//   out_o      out  valid/ready      packed_byte
//   lift_we_i  in   write enable     luminance lift register
//
// One item is taken per cycle while input is not stalled. A pixel passes the
// palette RAM read register, then the packing stage and its output register.
// Reset clears the palette through per-entry written flags, so the block is
// ready as soon as reset is released. Input stalls only when a pixel must
// emit a byte while the output register still holds one not yet taken.
// ----------------------------------------------------------------------------
module palette_to_mono_dither_packer (
  input  logic          clk_i,
  input  logic          rst_ni,
  pdmp_in_if.sink       in_i,
  pdmp_out_if.source    out_o,
  input  logic          lift_we_i,
  input  logic          lift_wdata_i
);

  pdmp_pkg::req_t req;
  pdmp_pkg::pix_t pix;
  logic           hold;
  logic           lift_q;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lift_q <= 1'b0;
    end else if (lift_we_i) begin
      lift_q <= lift_wdata_i;
    end
  end

  // Input transfer.
  assign in_i.ready = !hold;

  always_comb begin
    req.accept   = in_i.valid && !hold;
    req.action   = pdmp_pkg::action_e'(in_i.action);
    req.index    = in_i.index;
    req.red      = in_i.red;
    req.green    = in_i.green;
    req.blue     = in_i.blue;
    req.line_odd = in_i.line_odd;
    req.row_end  = in_i.row_end;
  end

  pdmp_palette u_palette (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .hold_i (hold),
    .pix_o  (pix)
  );

  pdmp_pack u_pack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix_i         (pix),
    .lift_i        (lift_q),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .packed_byte_o (out_o.packed_byte),
    .hold_o        (hold)
  );

  // Input is refused only while a finished byte waits at the output.
  a_stall_needs_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input stalled with the output register empty");

  // A new byte only ever comes from a pixel in the packing stage.
  a_byte_from_pixel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(pix.valid))
    else $error("byte appeared without a pixel in the packing stage");

  // A palette write never enters the packing stage.
  a_write_no_pixel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.action) |=> !pix.valid)
    else $error("palette write reached the packing stage");

endmodule

### test/palette_to_mono_dither_packer_tb.sv
// ----------------------------------------------------------------------------
// palette_to_mono_dither_packer_tb: self-checking bench for the mono packer
// Drives palette writes and pixel rows through the input channel and keeps
// a behavioural copy of the palette, the luminance lift setting and the byte
// being packed. Every byte taken from the output channel is compared with the
// oldest predicted byte. The sender idles in bursts and the receiver stalls
// on a changing pattern of its own.
// ----------------------------------------------------------------------------
module palette_to_mono_dither_packer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RUN_LIMIT = 200_000;

  // One item as the bench builds it and as it is seen on the input channel.
  typedef struct packed {
    pdmp_pkg::action_e                 action;
    logic [pdmp_pkg::INDEX_W-1:0]      index;
    logic [pdmp_pkg::COMP_W-1:0]       red;
    logic [pdmp_pkg::COMP_W-1:0]       green;
    logic [pdmp_pkg::COMP_W-1:0]       blue;
    logic                              line_odd;
    logic                              row_end;
  } pix_item_t;

  localparam int unsigned ITEM_W = $bits(pix_item_t);

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_PATTERN,
    RX_HEAVY
  } rx_mode_e;

  // Keeps the expected palette and packing state, and the bytes still owed.
  class mono_pack_scoreboard;
    logic [pdmp_pkg::PAL_W-1:0]   palette [pdmp_pkg::PAL_ENTRIES];
    logic [pdmp_pkg::BYTE_W-1:0]  acc;
    logic [1:0]                   slot;
    logic                         lift;
    logic [pdmp_pkg::BYTE_W-1:0]  expected_bytes [$];
    int unsigned                  mismatches;

    function new();
      foreach (palette[i]) palette[i] = '0;
      acc        = '0;
      slot       = '0;
      lift       = 1'b0;
      mismatches = 0;
    endfunction

    // Luminance from truncated weighted terms, then the two-row dither.
    function logic [1:0] dither_code(logic [pdmp_pkg::INDEX_W-1:0] idx, logic odd);
      int unsigned r, g, b, q;
      r = 0;
      g = 0;
      b = 0;
      if (int'(idx) < pdmp_pkg::PAL_ENTRIES) begin
        r = palette[idx][3*pdmp_pkg::COMP_W-1:2*pdmp_pkg::COMP_W];
        g = palette[idx][2*pdmp_pkg::COMP_W-1:pdmp_pkg::COMP_W];
        b = palette[idx][pdmp_pkg::COMP_W-1:0];
      end
      q = (r * 30) / 100 + (g * 59) / 100 + (b * 11) / 100;
      if (lift && idx != '0) q += 12;
      if (q < 12) return 2'd0;
      if (q < 25) return odd ? 2'd0 : 2'd1;
      if (q < 36) return 2'd2;
      if (q < 49) return odd ? 2'd2 : 2'd3;
      return 2'd3;
    endfunction

    // Called for every accepted input transfer.
    function void note_item(pix_item_t it);
      logic [1:0] code;
      if (it.action == pdmp_pkg::ACT_PAL_WR) begin
        if (int'(it.index) < pdmp_pkg::PAL_ENTRIES)
          palette[it.index] = {it.red, it.green, it.blue};
        return;
      end
      code = dither_code(it.index, it.line_odd);
      acc  = acc | (pdmp_pkg::BYTE_W'(code) << (6 - 2 * slot));
      if (slot == 2'd3 || it.row_end) begin
        expected_bytes.push_back(acc);
        acc  = '0;
        slot = '0;
      end else begin
        slot = slot + 2'd1;
      end
    endfunction

    // Called for every accepted output transfer.
    function void check_byte(logic [pdmp_pkg::BYTE_W-1:0] got);
      logic [pdmp_pkg::BYTE_W-1:0] want;
      if (expected_bytes.size() == 0) begin
        if (mismatches < 10) $display("unexpected byte 0x%02h with nothing pending", got);
        mismatches++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got !== want) begin
        if (mismatches < 10)
          $display("packed_byte mismatch: expected 0x%02h, got 0x%02h", want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic lift_we;
  logic lift_wdata;

  pdmp_in_if  in_ch ();
  pdmp_out_if out_ch ();

  mono_pack_scoreboard sb;

  int unsigned                   items_sent;
  int unsigned                   burst_left;
  int unsigned                   gap_max;
  int unsigned                   cycle_count;
  logic [pdmp_pkg::INDEX_W-1:0]  hot_idx [$];

  palette_to_mono_dither_packer u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_i         (in_ch),
    .out_o        (out_ch),
    .lift_we_i    (lift_we),
    .lift_wdata_i (lift_wdata)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a run that has not ended by the limit has hung.
  initial begin
    cycle_count = 0;
    do begin
      @(posedge clk);
      cycle_count++;
    end while (cycle_count < RUN_LIMIT);
    $display("** palette_to_mono_dither_packer: FAILED **");
    $finish;
  end

  // Monitor: register writes, input transfers and output transfers.
  always @(posedge clk) begin
    pix_item_t seen;
    if (rst_n) begin
      if (lift_we) sb.lift = lift_wdata;
      if (in_ch.valid && in_ch.ready) begin
        seen.action   = pdmp_pkg::action_e'(in_ch.action);
        seen.index    = in_ch.index;
        seen.red      = in_ch.red;
        seen.green    = in_ch.green;
        seen.blue     = in_ch.blue;
        seen.line_odd = in_ch.line_odd;
        seen.row_end  = in_ch.row_end;
        sb.note_item(seen);
      end
      if (out_ch.valid && out_ch.ready) sb.check_byte(out_ch.packed_byte);
    end
  end

  // Receiver: picks a new stall pattern whenever the current random span runs out.
  initial begin
    rx_mode_e    mode;
    int unsigned span;
    logic [7:0]  mask;
    out_ch.ready = 1'b0;
    mode = RX_FREE;
    span = 0;
    mask = 8'b1101_0110;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        span = $urandom_range(32, 400);
      end
      span--;
      mask = {mask[6:0], mask[7]};
      case (mode)
        RX_FREE: begin
          out_ch.ready <= 1'b1;
        end
        RX_LIGHT: begin
          out_ch.ready <= ($urandom_range(0, 9) >= 3);
        end
        RX_PATTERN: begin
          out_ch.ready <= mask[0];
        end
        default: begin
          out_ch.ready <= ($urandom_range(0, 9) >= 7);
        end
      endcase
    end
  end

  // A pixel item; the colour fields are ignored but still toggled.
  function automatic pix_item_t pixel(logic [pdmp_pkg::INDEX_W-1:0] idx, logic odd,
                                      logic last);
    pix_item_t it;
    it.action   = pdmp_pkg::ACT_PIXEL;
    it.index    = idx;
    it.red      = pdmp_pkg::COMP_W'($urandom);
    it.green    = pdmp_pkg::COMP_W'($urandom);
    it.blue     = pdmp_pkg::COMP_W'($urandom);
    it.line_odd = odd;
    it.row_end  = last;
    return it;
  endfunction

  // A palette write; the row flags are ignored but still toggled.
  function automatic pix_item_t pal_write(logic [pdmp_pkg::INDEX_W-1:0] idx,
                                          logic [pdmp_pkg::COMP_W-1:0] r,
                                          logic [pdmp_pkg::COMP_W-1:0] g,
                                          logic [pdmp_pkg::COMP_W-1:0] b);
    pix_item_t it;
    it.action   = pdmp_pkg::ACT_PAL_WR;
    it.index    = idx;
    it.red      = r;
    it.green    = g;
    it.blue     = b;
    it.line_odd = 1'($urandom);
    it.row_end  = 1'($urandom);
    hot_idx.push_back(idx);
    if (hot_idx.size() > 16) void'(hot_idx.pop_front());
    return it;
  endfunction

  // Random palette write, with a share of extreme component values.
  function automatic pix_item_t random_pal_write();
    logic [pdmp_pkg::INDEX_W-1:0] idx;
    if ($urandom_range(0, 3) == 0 && hot_idx.size() > 0)
      idx = hot_idx[$urandom_range(0, hot_idx.size() - 1)];
    else
      idx = pdmp_pkg::INDEX_W'($urandom);
    if ($urandom_range(0, 3) == 0)
      return pal_write(idx, pdmp_pkg::COMP_W'($urandom_range(0, 1) * 63),
                       pdmp_pkg::COMP_W'($urandom_range(0, 1) * 63),
                       pdmp_pkg::COMP_W'($urandom_range(0, 1) * 63));
    return pal_write(idx, pdmp_pkg::COMP_W'($urandom), pdmp_pkg::COMP_W'($urandom),
                     pdmp_pkg::COMP_W'($urandom));
  endfunction

  // Pixel index: mostly recently written entries, so lookups see real colours.
  function automatic logic [pdmp_pkg::INDEX_W-1:0] pick_index();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return '0;
    if (roll < 25 && hot_idx.size() > 0) return hot_idx[$];
    if (roll < 70 && hot_idx.size() > 0) return hot_idx[$urandom_range(0, hot_idx.size() - 1)];
    return pdmp_pkg::INDEX_W'($urandom);
  endfunction

  // Presents one item and holds it until its transfer, idling between bursts.
  task automatic send_item(input pix_item_t it);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid    <= 1'b1;
    in_ch.action   <= it.action;
    in_ch.index    <= it.index;
    in_ch.red      <= it.red;
    in_ch.green    <= it.green;
    in_ch.blue     <= it.blue;
    in_ch.line_odd <= it.line_odd;
    in_ch.row_end  <= it.row_end;
    items_sent++;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // One row of pixels with palette writes mixed in. A noisy row scatters
  // parity and row ends instead of keeping them well formed.
  task automatic send_row(input bit noisy);
    int unsigned len;
    logic        odd;
    pix_item_t   it;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
    odd = 1'($urandom);
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(0, 7) == 0) send_item(random_pal_write());
      it = pixel(pick_index(), noisy ? 1'($urandom) : odd,
                 (k == len - 1) || (noisy && $urandom_range(0, 5) == 0));
      send_item(it);
    end
  endtask

  // Lets every owed byte arrive, then allows for pixels still in flight.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_lift(input logic value);
    @(negedge clk);
    lift_we    <= 1'b1;
    lift_wdata <= value;
    @(negedge clk);
    lift_we    <= 1'b0;
  endtask

  // Stimulus: directed checks, then phases of random rows.
  initial begin
    logic        phase_lift [6];
    int unsigned phase_gap [6];
    pix_item_t   raw;
    sb = new();
    phase_lift = '{1'b1, 1'b0, 1'b1, 1'b0, 1'($urandom), 1'b1};
    phase_gap  = '{0, 3, 8, 0, 12, 2};
    rst_n          = 1'b0;
    lift_we        = 1'b0;
    lift_wdata     = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.action   = pdmp_pkg::ACT_PIXEL;
    in_ch.index    = '0;
    in_ch.red      = '0;
    in_ch.green    = '0;
    in_ch.blue     = '0;
    in_ch.line_odd = 1'b0;
    in_ch.row_end  = 1'b0;
    items_sent     = 0;
    burst_left     = 0;
    gap_max        = 2;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // A lone pixel from the cleared palette.
    send_item(pixel(8'd0, 1'b0, 1'b1));
    // Entries landing in each luminance band, including the exact dark threshold.
    send_item(pal_write(8'd255, 6'd63, 6'd63, 6'd63));
    send_item(pal_write(8'd2, 6'd0, 6'd22, 6'd0));
    send_item(pal_write(8'd3, 6'd0, 6'd51, 6'd0));
    send_item(pal_write(8'd4, 6'd63, 6'd38, 6'd0));
    send_item(pal_write(8'd128, 6'd0, 6'd20, 6'd0));
    send_item(pal_write(8'd5, 6'd0, 6'd0, 6'd63));
    // Full even row byte, then the odd row dither with a row end in slot 3.
    send_item(pixel(8'd255, 1'b0, 1'b0));
    send_item(pixel(8'd2, 1'b0, 1'b0));
    send_item(pixel(8'd3, 1'b0, 1'b0));
    send_item(pixel(8'd4, 1'b0, 1'b0));
    send_item(pixel(8'd255, 1'b1, 1'b0));
    send_item(pixel(8'd2, 1'b1, 1'b0));
    send_item(pixel(8'd3, 1'b1, 1'b0));
    send_item(pixel(8'd4, 1'b1, 1'b1));
    // Partial bytes flushed at the end of short rows.
    send_item(pixel(8'd128, 1'b0, 1'b0));
    send_item(pixel(8'd5, 1'b0, 1'b1));
    send_item(pixel(8'd1, 1'b1, 1'b0));
    send_item(pixel(8'd255, 1'b1, 1'b0));
    send_item(pixel(8'd2, 1'b1, 1'b1));
    // A pixel reading the entry written in the transfer just before it.
    send_item(pal_write(8'd6, 6'd63, 6'd0, 6'd0));
    send_item(pixel(8'd6, 1'b0, 1'b1));

    for (int p = 0; p < 6; p++) begin
      drain_results();
      write_lift(phase_lift[p]);
      gap_max = phase_gap[p];
      while (items_sent < 25 + (p + 1) * 255) begin
        if ($urandom_range(0, 9) == 0) begin
          raw = pix_item_t'(ITEM_W'($urandom));
          send_item(raw);
        end else begin
          send_row($urandom_range(0, 7) == 0);
        end
      end
    end

    drain_results();
    repeat (4) @(negedge clk);
    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
      $display("** palette_to_mono_dither_packer: PASSED **");
    end else begin
      $display("** palette_to_mono_dither_packer: FAILED **");
    end
    $finish;
  end

endmodule
